>>> design/rgbm_pkg.sv
package rgbm_pkg;

  typedef enum logic [1:0] {
    REQ_SET_DOT = 2'd0,
    REQ_CLEAR   = 2'd1,
    REQ_DRAW    = 2'd2,
    REQ_TICK    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ADDR   = 3'd1,
    PH_SHIFT  = 3'd2,
    PH_LE_HI  = 3'd3,
    PH_LE_LO  = 3'd4,
    PH_OE_LO  = 3'd5,
    PH_DWELL  = 3'd6,
    PH_FINISH = 3'd7
  } phase_e;

  // pin levels driven toward the panel plus the pass flag
  typedef struct packed {
    logic [2:0] row;
    logic       oe;
    logic       le;
    logic       sdi;
    logic       clk;
    logic       busy;
  } pins_t;

  localparam int unsigned BlueOffset   = 16;
  localparam int unsigned RedOffset    = 32;
  localparam int unsigned OddRowOffset = 48;

  localparam logic [15:0] DwellReset = 16'd300;
  localparam logic [2:0]  RowPark    = 3'd7;

endpackage

>>> design/rgbm_frame_store.sv
module rgbm_frame_store #(
  parameter int unsigned SCAN_LINES = 8,
  parameter int unsigned LINE_BITS  = 96,
  localparam int unsigned LW = (SCAN_LINES > 1) ? $clog2(SCAN_LINES) : 1,
  localparam int unsigned BW = $clog2(LINE_BITS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          set_i,
  input  logic          clr_i,
  input  logic [3:0]    dot_x_i,
  input  logic [3:0]    dot_y_i,
  input  logic          red_i,
  input  logic          green_i,
  input  logic          blue_i,
  input  logic [LW-1:0] rd_line_i,
  input  logic [BW-1:0] rd_bit_i,
  output logic          rd_data_o
);

  logic [SCAN_LINES-1:0][LINE_BITS-1:0] frame_q;

  logic [2:0]    dot_line;
  logic [5:0]    dot_off;
  logic          line_ok;
  logic [LW-1:0] wr_line;
  logic [BW-1:0] off_g;
  logic [BW-1:0] off_b;
  logic [BW-1:0] off_r;

  assign dot_line = dot_y_i[3:1];
  assign dot_off  = {2'b00, dot_x_i} + (dot_y_i[0] ? 6'(rgbm_pkg::OddRowOffset) : 6'd0);
  assign line_ok  = (32'(dot_line) < SCAN_LINES) &&
                    (32'(dot_off) + rgbm_pkg::RedOffset < LINE_BITS);
  assign wr_line  = LW'(dot_line);
  assign off_g    = BW'(dot_off);
  assign off_b    = BW'(32'(dot_off) + rgbm_pkg::BlueOffset);
  assign off_r    = BW'(32'(dot_off) + rgbm_pkg::RedOffset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (clr_i) begin
      frame_q <= '0;
    end else if (set_i && line_ok) begin
      frame_q[wr_line][off_g] <= green_i;
      frame_q[wr_line][off_b] <= blue_i;
      frame_q[wr_line][off_r] <= red_i;
    end
  end

  assign rd_data_o = frame_q[rd_line_i][rd_bit_i];

endmodule

>>> design/rgbm_scan_seq.sv
module rgbm_scan_seq #(
  parameter int unsigned SCAN_LINES = 8,
  parameter int unsigned LINE_BITS  = 96,
  localparam int unsigned LW = (SCAN_LINES > 1) ? $clog2(SCAN_LINES) : 1,
  localparam int unsigned BW = $clog2(LINE_BITS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  rgbm_pkg::req_e  req_i,
  input  logic [15:0]     dwell_ticks_i,
  input  logic            frame_bit_i,
  output logic [LW-1:0]   rd_line_o,
  output logic [BW-1:0]   rd_bit_o,
  output rgbm_pkg::pins_t pins_o
);

  localparam logic [LW-1:0] LastLine = LW'(SCAN_LINES - 1);
  localparam logic [BW-1:0] LastBit  = BW'(LINE_BITS - 1);

  rgbm_pkg::phase_e phase_q, phase_d;
  logic [LW-1:0]    line_q, line_d;
  logic [BW-1:0]    bit_q, bit_d;
  logic             half_q, half_d;
  logic [15:0]      dwell_q, dwell_d;
  rgbm_pkg::pins_t  pins_q, pins_d;
  logic [15:0]      dwell_dec;

  assign dwell_dec = dwell_q - 16'd1;

  always_comb begin
    phase_d = phase_q;
    line_d  = line_q;
    bit_d   = bit_q;
    half_d  = half_q;
    dwell_d = dwell_q;
    pins_d  = pins_q;
    if (step_i) begin
      unique case (req_i)
        rgbm_pkg::REQ_SET_DOT, rgbm_pkg::REQ_CLEAR: begin
        end
        rgbm_pkg::REQ_DRAW: begin
          if (phase_q == rgbm_pkg::PH_IDLE) begin
            line_d  = '0;
            bit_d   = '0;
            half_d  = 1'b0;
            phase_d = rgbm_pkg::PH_ADDR;
          end
        end
        rgbm_pkg::REQ_TICK: begin
          unique case (phase_q)
            rgbm_pkg::PH_IDLE: begin
            end
            rgbm_pkg::PH_ADDR: begin
              pins_d.row = ~(3'(line_q));
              pins_d.oe  = 1'b1;
              bit_d      = '0;
              half_d     = 1'b0;
              phase_d    = rgbm_pkg::PH_SHIFT;
            end
            rgbm_pkg::PH_SHIFT: begin
              if (!half_q) begin
                pins_d.sdi = frame_bit_i;
                pins_d.clk = 1'b1;
                half_d     = 1'b1;
              end else begin
                pins_d.clk = 1'b0;
                half_d     = 1'b0;
                bit_d      = bit_q + 1'b1;
                if (bit_q == LastBit) begin
                  phase_d = rgbm_pkg::PH_LE_HI;
                end
              end
            end
            rgbm_pkg::PH_LE_HI: begin
              pins_d.le = 1'b1;
              phase_d   = rgbm_pkg::PH_LE_LO;
            end
            rgbm_pkg::PH_LE_LO: begin
              pins_d.le = 1'b0;
              phase_d   = rgbm_pkg::PH_OE_LO;
            end
            rgbm_pkg::PH_OE_LO: begin
              pins_d.oe = 1'b0;
              dwell_d   = dwell_ticks_i;
              if (dwell_ticks_i != 16'd0) begin
                phase_d = rgbm_pkg::PH_DWELL;
              end else if (line_q != LastLine) begin
                line_d  = line_q + 1'b1;
                phase_d = rgbm_pkg::PH_ADDR;
              end else begin
                phase_d = rgbm_pkg::PH_FINISH;
              end
            end
            rgbm_pkg::PH_DWELL: begin
              dwell_d = dwell_dec;
              if (dwell_dec == 16'd0) begin
                if (line_q != LastLine) begin
                  line_d  = line_q + 1'b1;
                  phase_d = rgbm_pkg::PH_ADDR;
                end else begin
                  phase_d = rgbm_pkg::PH_FINISH;
                end
              end
            end
            rgbm_pkg::PH_FINISH: begin
              pins_d.row = rgbm_pkg::RowPark;
              pins_d.oe  = 1'b1;
              line_d     = '0;
              phase_d    = rgbm_pkg::PH_IDLE;
            end
          endcase
        end
      endcase
    end
    pins_d.busy = (phase_d != rgbm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rgbm_pkg::PH_IDLE;
      line_q  <= '0;
      bit_q   <= '0;
      half_q  <= 1'b0;
      dwell_q <= '0;
      pins_q  <= '{row: rgbm_pkg::RowPark, oe: 1'b1, le: 1'b0, sdi: 1'b0, clk: 1'b0,
                   busy: 1'b0};
    end else begin
      phase_q <= phase_d;
      line_q  <= line_d;
      bit_q   <= bit_d;
      half_q  <= half_d;
      dwell_q <= dwell_d;
      pins_q  <= pins_d;
    end
  end

  assign rd_line_o = line_q;
  assign rd_bit_o  = bit_q;
  assign pins_o    = pins_d;

  // the clock half flag only lives inside a line shift
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> phase_q == rgbm_pkg::PH_SHIFT)
    else $error("clock half set outside shift phase");

  // an idle sequencer always parks on line zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rgbm_pkg::PH_IDLE |-> line_q == '0)
    else $error("idle sequencer left off line zero");

  // stored busy flag tracks the phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pins_q.busy == (phase_q != rgbm_pkg::PH_IDLE))
    else $error("busy flag out of step with phase");

endmodule

>>> design/rgb_led_matrix_scan_driver.sv
// Frame buffer and scan driver for a multiplexed RGB LED matrix of SCAN_LINES
// lines of LINE_BITS serial bits. Every accepted transaction (set dot, clear,
// start draw, tick) yields exactly one result transaction carrying the panel
// pin levels after that transaction; a tick moves the pin sequence one step.
// One transaction is taken per clock while the output is not back-pressured;
// it is held in the input register, and its result is then captured in the
// output register as the scan sequencer and flip-flop frame store update; the
// input register can hold one more transaction while an earlier result waits.
// dwell_ticks may only be written while no transaction is in flight.
module rgb_led_matrix_scan_driver #(
  parameter int unsigned SCAN_LINES = 8,
  parameter int unsigned LINE_BITS  = 96
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  dot_x_i,
  input  logic [3:0]  dot_y_i,
  input  logic        red_on_i,
  input  logic        green_on_i,
  input  logic        blue_on_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  row_select_o,
  output logic        output_enable_o,
  output logic        latch_enable_o,
  output logic        serial_data_o,
  output logic        shift_clock_o,
  output logic        frame_busy_o
);

  localparam int unsigned LW = (SCAN_LINES > 1) ? $clog2(SCAN_LINES) : 1;
  localparam int unsigned BW = $clog2(LINE_BITS);

  logic [15:0] dwell_q;

  logic       in_valid_q;
  logic [1:0] req_q;
  logic [3:0] dot_x_q;
  logic [3:0] dot_y_q;
  logic       red_q;
  logic       green_q;
  logic       blue_q;

  logic            out_valid_q;
  rgbm_pkg::pins_t out_pins_q;
  rgbm_pkg::pins_t pins_next;

  rgbm_pkg::req_e req;
  logic           advance;
  logic           take;
  logic [LW-1:0]  rd_line;
  logic [BW-1:0]  rd_bit;
  logic           rd_data;

  assign req        = rgbm_pkg::req_e'(req_q);
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_q <= rgbm_pkg::DwellReset;
    end else if (cfg_we_i) begin
      dwell_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q   <= req_type_i;
      dot_x_q <= dot_x_i;
      dot_y_q <= dot_y_i;
      red_q   <= red_on_i;
      green_q <= green_on_i;
      blue_q  <= blue_on_i;
    end
  end

  rgbm_frame_store #(
    .SCAN_LINES(SCAN_LINES),
    .LINE_BITS (LINE_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .set_i    (advance && req == rgbm_pkg::REQ_SET_DOT),
    .clr_i    (advance && req == rgbm_pkg::REQ_CLEAR),
    .dot_x_i  (dot_x_q),
    .dot_y_i  (dot_y_q),
    .red_i    (red_q),
    .green_i  (green_q),
    .blue_i   (blue_q),
    .rd_line_i(rd_line),
    .rd_bit_i (rd_bit),
    .rd_data_o(rd_data)
  );

  rgbm_scan_seq #(
    .SCAN_LINES(SCAN_LINES),
    .LINE_BITS (LINE_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .req_i        (req),
    .dwell_ticks_i(dwell_q),
    .frame_bit_i  (rd_data),
    .rd_line_o    (rd_line),
    .rd_bit_o     (rd_bit),
    .pins_o       (pins_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pins_q <= pins_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign row_select_o    = out_pins_q.row;
  assign output_enable_o = out_pins_q.oe;
  assign latch_enable_o  = out_pins_q.le;
  assign serial_data_o   = out_pins_q.sdi;
  assign shift_clock_o   = out_pins_q.clk;
  assign frame_busy_o    = out_pins_q.busy;

  // input side only stalls when a result is held up downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // latch pulse always happens while the panel is blanked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && latch_enable_o |-> output_enable_o)
    else $error("latch pulse with outputs enabled");

  // shift clock only toggles during a frame pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shift_clock_o |-> frame_busy_o)
    else $error("shift clock high outside a frame pass");

endmodule
